### rtl/core/rotb_pkg.sv
// Shared types and constants for the bilinear image rotation block.
// Used by every module under rtl/core; depends on nothing.
package rotb_pkg;

    localparam int MEM_AW  = 16;
    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = 3;
    localparam int O_DEPTH = 8;
    localparam int O_AW    = 3;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [2:0] REG_COS        = 3'd4;
    localparam logic [2:0] REG_SIN        = 3'd5;

    localparam logic [31:0] WHITE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [8:0]  src_width;
        logic [8:0]  src_height;
        logic [9:0]  dst_width;
        logic [9:0]  dst_height;
        logic [15:0] cos_q14;
        logic [15:0] sin_q14;
    } rotb_cfg_t;

    // One classified item on its way from the front end to the pixel engine
    typedef struct packed {
        logic        cmd;
        logic        in_src;
        logic        lastc;
        logic        lastr;
        logic [7:0]  fv;
        logic [7:0]  fh;
        logic [MEM_AW-1:0] addr;
        logic [8:0]  stride;
        logic [31:0] pixel;
    } rotb_job_t;

endpackage

### rtl/core/rotb_front.sv
// Front end: maps destination pixels back into the source, classifies them
// and forms the base memory address. Depends on rotb_pkg.
module rotb_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               cmd,
    input  logic [15:0]        src_index,
    input  logic [31:0]        pixel_in,
    input  logic [8:0]         dst_row,
    input  logic [8:0]         dst_col,
    input  rotb_pkg::rotb_cfg_t cfg,
    output logic               out_valid,
    output rotb_pkg::rotb_job_t out_job,
    output logic [1:0]         busy
);
    import rotb_pkg::*;

    logic signed [18:0] x8;
    logic signed [18:0] y8;
    logic signed [34:0] xc_next;
    logic signed [34:0] ys_next;
    logic signed [34:0] yc_next;
    logic signed [34:0] xs_next;

    logic               s1_v_reg;
    logic               s1_cmd_reg;
    logic [15:0]        s1_idx_reg;
    logic [31:0]        s1_pix_reg;
    logic signed [34:0] s1_xc_reg;
    logic signed [34:0] s1_ys_reg;
    logic signed [34:0] s1_yc_reg;
    logic signed [34:0] s1_xs_reg;

    logic signed [35:0] sum_c;
    logic signed [35:0] sum_r;
    logic signed [23:0] col8;
    logic signed [23:0] row8;
    logic signed [23:0] colmax;
    logic signed [23:0] rowmax;
    logic               inside_next;

    logic               s2_v_reg;
    logic               s2_cmd_reg;
    logic [15:0]        s2_idx_reg;
    logic [31:0]        s2_pix_reg;
    logic               s2_inside_reg;
    logic               s2_lastc_reg;
    logic               s2_lastr_reg;
    logic [7:0]         s2_r_reg;
    logic [7:0]         s2_c_reg;
    logic [7:0]         s2_fv_reg;
    logic [7:0]         s2_fh_reg;

    logic [16:0]        row_base;
    rotb_job_t          job_next;
    logic               s3_v_reg;
    rotb_job_t          s3_job_reg;

    // Stage 1: centered Q.8 coordinates and the four rotation products
    assign x8 = $signed({2'b00, dst_col, 8'd0}) - $signed({2'b00, cfg.dst_width[9:1], 8'd0})
              + 19'sd128;
    assign y8 = $signed({2'b00, dst_row, 8'd0}) - $signed({2'b00, cfg.dst_height[9:1], 8'd0})
              + 19'sd128;
    assign xc_next = x8 * $signed(cfg.cos_q14);
    assign ys_next = y8 * $signed(cfg.sin_q14);
    assign yc_next = y8 * $signed(cfg.cos_q14);
    assign xs_next = x8 * $signed(cfg.sin_q14);

    always_ff @(posedge clk)
    begin
        s1_cmd_reg <= cmd;
        s1_idx_reg <= src_index;
        s1_pix_reg <= pixel_in;
        s1_xc_reg  <= xc_next;
        s1_ys_reg  <= ys_next;
        s1_yc_reg  <= yc_next;
        s1_xs_reg  <= xs_next;
    end

    // Stage 2: floor shift, source center offset, bounds check
    assign sum_c  = s1_xc_reg + s1_ys_reg;
    assign sum_r  = s1_yc_reg - s1_xs_reg;
    assign col8   = $signed(sum_c[35:14]) + $signed({8'd0, cfg.src_width[8:1], 8'd0})
                  - 24'sd128;
    assign row8   = $signed(sum_r[35:14]) + $signed({8'd0, cfg.src_height[8:1], 8'd0})
                  - 24'sd128;
    assign colmax = $signed({7'd0, cfg.src_width, 8'd0}) - 24'sd256;
    assign rowmax = $signed({7'd0, cfg.src_height, 8'd0}) - 24'sd256;
    assign inside_next = (col8 >= 24'sd0) && (row8 >= 24'sd0)
                      && (col8 <= colmax) && (row8 <= rowmax);

    always_ff @(posedge clk)
    begin
        s2_cmd_reg    <= s1_cmd_reg;
        s2_idx_reg    <= s1_idx_reg;
        s2_pix_reg    <= s1_pix_reg;
        s2_inside_reg <= inside_next;
        s2_lastc_reg  <= (col8 >= colmax);
        s2_lastr_reg  <= (row8 >= rowmax);
        s2_r_reg      <= row8[15:8];
        s2_c_reg      <= col8[15:8];
        s2_fv_reg     <= row8[7:0];
        s2_fh_reg     <= col8[7:0];
    end

    // Stage 3: linear address of the top-left neighbor for reads, source index for writes
    assign row_base = s2_r_reg * cfg.src_width;

    always_comb
    begin
        job_next.cmd    = s2_cmd_reg;
        job_next.in_src = s2_inside_reg;
        job_next.lastc  = s2_lastc_reg;
        job_next.lastr  = s2_lastr_reg;
        job_next.fv     = s2_fv_reg;
        job_next.fh     = s2_fh_reg;
        job_next.stride = cfg.src_width;
        job_next.pixel  = s2_pix_reg;
        if (s2_cmd_reg == CMD_WRITE)
        begin
            job_next.addr = s2_idx_reg;
        end
        else
        begin
            job_next.addr = row_base[MEM_AW-1:0] + {8'd0, s2_c_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        s3_job_reg <= job_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    assign out_valid = s3_v_reg;
    assign out_job   = s3_job_reg;
    assign busy      = 2'({1'b0, s1_v_reg} + {1'b0, s2_v_reg} + {1'b0, s3_v_reg});

endmodule

### rtl/core/rotb_queue.sv
// Short queue of classified items between the front end and the pixel engine.
// Depends on rotb_pkg.
module rotb_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  rotb_pkg::rotb_job_t wr_job,
    input  logic                rd,
    output logic                rd_valid,
    output rotb_pkg::rotb_job_t rd_job,
    output logic [rotb_pkg::Q_AW:0] count
);
    import rotb_pkg::*;

    rotb_job_t       slot_reg [Q_DEPTH];
    logic [Q_AW-1:0] wptr_reg;
    logic [Q_AW-1:0] rptr_reg;
    logic [Q_AW:0]   cnt_reg;
    logic [Q_AW:0]   cnt_next;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wptr_reg] <= wr_job;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (rd)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    assign rd_valid = (cnt_reg != '0);
    assign rd_job   = slot_reg[rptr_reg];
    assign count    = cnt_reg;

endmodule

### rtl/core/rotb_back.sv
// Pixel engine: source memory (two copies, two read ports each), bilinear
// blend and the result queue. Depends on rotb_pkg.
module rotb_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  rotb_pkg::rotb_job_t job,
    output logic                job_take,
    input  logic                pop,
    output logic                empty,
    output logic [31:0]         pixel_out,
    output logic                inside_res
);
    import rotb_pkg::*;

    logic [31:0]       mem_a_reg [2**MEM_AW];
    logic [31:0]       mem_b_reg [2**MEM_AW];
    logic [MEM_AW-1:0] addr_r;
    logic [MEM_AW-1:0] addr_b;
    logic [MEM_AW-1:0] addr_d;
    logic              do_write;

    logic [31:0] rd_p_reg;
    logic [31:0] rd_r_reg;
    logic [31:0] rd_b_reg;
    logic [31:0] rd_d_reg;
    logic        b1_v_reg;
    logic        b1_inside_reg;
    logic        b1_lastc_reg;
    logic        b1_lastr_reg;
    logic [7:0]  b1_fv_reg;
    logic [7:0]  b1_fh_reg;

    logic [31:0] px_r;
    logic [31:0] px_b;
    logic [31:0] px_d;
    logic [8:0]  wv_p;
    logic [8:0]  wh_p;
    logic [15:0] v0_next [4];
    logic [15:0] v1_next [4];

    logic        b2_v_reg;
    logic        b2_inside_reg;
    logic [7:0]  b2_fh_reg;
    logic [15:0] v0_reg [4];
    logic [15:0] v1_reg [4];

    logic [31:0] blend;
    logic [32:0] res_next;

    logic [32:0]     ofifo_reg [O_DEPTH];
    logic [O_AW-1:0] owptr_reg;
    logic [O_AW-1:0] orptr_reg;
    logic [O_AW:0]   ocnt_reg;
    logic [O_AW:0]   ocnt_next;
    logic [O_AW:0]   inflight;
    logic            opop;

    // Take an item only when the result queue has room for everything in flight
    assign inflight = {{(O_AW){1'b0}}, b1_v_reg} + {{(O_AW){1'b0}}, b2_v_reg};
    assign job_take = job_valid && ((ocnt_reg + inflight) < (O_AW+1)'(O_DEPTH));
    assign do_write = job_take && (job.cmd == CMD_WRITE);

    assign addr_r = job.addr + 1'b1;
    assign addr_b = job.addr + {{(MEM_AW-9){1'b0}}, job.stride};
    assign addr_d = addr_b + 1'b1;

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem_a_reg[job.addr] <= job.pixel;
        end
        rd_p_reg <= mem_a_reg[job.addr];
        rd_r_reg <= mem_a_reg[addr_r];
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem_b_reg[job.addr] <= job.pixel;
        end
        rd_b_reg <= mem_b_reg[addr_b];
        rd_d_reg <= mem_b_reg[addr_d];
    end

    always_ff @(posedge clk)
    begin
        b1_inside_reg <= job.in_src;
        b1_lastc_reg  <= job.lastc;
        b1_lastr_reg  <= job.lastr;
        b1_fv_reg     <= job.fv;
        b1_fh_reg     <= job.fh;
    end

    // Vertical blend. On the last row or column the weight toward the missing
    // neighbor is zero, so drop those neighbors to keep unread entries out.
    assign px_r = b1_lastc_reg ? 32'd0 : rd_r_reg;
    assign px_b = b1_lastr_reg ? 32'd0 : rd_b_reg;
    assign px_d = (b1_lastc_reg || b1_lastr_reg) ? 32'd0 : rd_d_reg;
    assign wv_p = 9'd256 - {1'b0, b1_fv_reg};

    always_comb
    begin
        logic [16:0] t0;
        logic [16:0] t1;
        for (int ch = 0; ch < 4; ch++)
        begin
            t0 = rd_p_reg[8*ch +: 8] * wv_p + px_b[8*ch +: 8] * b1_fv_reg;
            t1 = px_r[8*ch +: 8] * wv_p + px_d[8*ch +: 8] * b1_fv_reg;
            v0_next[ch] = t0[15:0];
            v1_next[ch] = t1[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        b2_inside_reg <= b1_inside_reg;
        b2_fh_reg     <= b1_fh_reg;
        for (int ch = 0; ch < 4; ch++)
        begin
            v0_reg[ch] <= v0_next[ch];
            v1_reg[ch] <= v1_next[ch];
        end
    end

    // Horizontal blend and truncation to a byte
    assign wh_p = 9'd256 - {1'b0, b2_fh_reg};

    always_comb
    begin
        logic [24:0] t;
        for (int ch = 0; ch < 4; ch++)
        begin
            t = v0_reg[ch] * wh_p + v1_reg[ch] * b2_fh_reg;
            blend[8*ch +: 8] = t[23:16];
        end
    end

    assign res_next = b2_inside_reg ? {1'b1, blend} : {1'b0, WHITE};

    always_ff @(posedge clk)
    begin
        if (b2_v_reg)
        begin
            ofifo_reg[owptr_reg] <= res_next;
        end
    end

    assign opop = pop && (ocnt_reg != '0);

    always_comb
    begin
        ocnt_next = ocnt_reg;
        if (b2_v_reg && !opop)
        begin
            ocnt_next = ocnt_reg + 1'b1;
        end
        else if (opop && !b2_v_reg)
        begin
            ocnt_next = ocnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg  <= 1'b0;
            b2_v_reg  <= 1'b0;
            owptr_reg <= '0;
            orptr_reg <= '0;
            ocnt_reg  <= '0;
        end
        else
        begin
            b1_v_reg <= job_take && (job.cmd == CMD_READ);
            b2_v_reg <= b1_v_reg;
            if (b2_v_reg)
            begin
                owptr_reg <= owptr_reg + 1'b1;
            end
            if (opop)
            begin
                orptr_reg <= orptr_reg + 1'b1;
            end
            ocnt_reg <= ocnt_next;
        end
    end

    assign empty      = (ocnt_reg == '0);
    assign pixel_out  = ofifo_reg[orptr_reg][31:0];
    assign inside_res = ofifo_reg[orptr_reg][32];

endmodule

### rtl/core/image_rotate_bilinear.sv
// Top level of the bilinear image rotation block: configuration registers,
// front end, item queue and pixel engine. Depends on rotb_pkg and rotb_* modules.
//
//   channel   direction  handshake            payload
//   input     in         push / full          cmd, src_index, pixel_in, dst_row, dst_col
//   result    out        empty / pop          pixel_out, inside_res
//   config    in         cfg_we (no wait)     cfg_index, cfg_data
//
// One item per cycle sustained while full stays low; a request passes the 3 front stages,
// the item queue, the memory read and the vertical and horizontal blend before it
// reaches the result queue. The rate is set by the two dual-read copies of the source
// memory, which give all four neighbors together. Source writes yield no
// result. full rises when the item queue cannot take what the front end holds;
// the engine holds items while the result queue is short of room.
// Reset clears control state and presets the configuration; the source memory is not cleared.
module image_rotate_bilinear (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        cmd,
    input  logic [15:0] src_index,
    input  logic [31:0] pixel_in,
    input  logic [8:0]  dst_row,
    input  logic [8:0]  dst_col,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] pixel_out,
    output logic        inside_res,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import rotb_pkg::*;

    rotb_cfg_t     cfg_reg;
    logic          accept;
    logic          f_valid;
    rotb_job_t     f_job;
    logic [1:0]    f_busy;
    logic          q_valid;
    rotb_job_t     q_job;
    logic [Q_AW:0] q_count;
    logic          q_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width  <= 9'd256;
            cfg_reg.src_height <= 9'd256;
            cfg_reg.dst_width  <= 10'd256;
            cfg_reg.dst_height <= 10'd256;
            cfg_reg.cos_q14    <= 16'd16384;
            cfg_reg.sin_q14    <= 16'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SRC_WIDTH:  cfg_reg.src_width  <= cfg_data[8:0];
                REG_SRC_HEIGHT: cfg_reg.src_height <= cfg_data[8:0];
                REG_DST_WIDTH:  cfg_reg.dst_width  <= cfg_data[9:0];
                REG_DST_HEIGHT: cfg_reg.dst_height <= cfg_data[9:0];
                REG_COS:        cfg_reg.cos_q14    <= cfg_data;
                REG_SIN:        cfg_reg.sin_q14    <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Reserve queue space for every item still in the front end
    assign full   = ((q_count + {{(Q_AW-1){1'b0}}, f_busy}) >= (Q_AW+1)'(Q_DEPTH));
    assign accept = push && !full;

    rotb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .cmd       (cmd),
        .src_index (src_index),
        .pixel_in  (pixel_in),
        .dst_row   (dst_row),
        .dst_col   (dst_col),
        .cfg       (cfg_reg),
        .out_valid (f_valid),
        .out_job   (f_job),
        .busy      (f_busy)
    );

    rotb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (f_valid),
        .wr_job   (f_job),
        .rd       (q_take),
        .rd_valid (q_valid),
        .rd_job   (q_job),
        .count    (q_count)
    );

    rotb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (q_valid),
        .job        (q_job),
        .job_take   (q_take),
        .pop        (pop),
        .empty      (empty),
        .pixel_out  (pixel_out),
        .inside_res (inside_res)
    );

endmodule

### sim/image_rotate_bilinear_tb.sv
// Testbench for image_rotate_bilinear: writes source pixels, requests rotated
// pixels and checks each against a bilinear predictor. Depends on rotb_pkg.
module image_rotate_bilinear_tb;
    import rotb_pkg::*;

    localparam int CLEAR_LAT = 12;
    localparam int WD_LIMIT  = 2000;

    typedef struct {
        logic [31:0] pix;
        logic        in_img;
    } rot_res_t;

    typedef struct {
        logic        cmd;
        logic [15:0] idx;
        logic [31:0] pix;
        logic [8:0]  row;
        logic [8:0]  col;
        logic        known;
        logic [31:0] exp_pix;
        logic        exp_inside;
    } stim_row_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        push = 0;
    logic        full;
    logic        cmd = 0;
    logic [15:0] src_index = 0;
    logic [31:0] pixel_in = 0;
    logic [8:0]  dst_row = 0;
    logic [8:0]  dst_col = 0;
    logic        empty;
    logic        pop = 0;
    logic [31:0] pixel_out;
    logic        inside_res;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = REG_SRC_WIDTH;
    logic [15:0] cfg_data = 0;

    image_rotate_bilinear dut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // predictor state
    logic [31:0] src_img [int];
    logic [8:0]  pw_sw, pw_sh;
    logic [9:0]  pw_dw, pw_dh;
    logic signed [15:0] pw_cos, pw_sin;

    rot_res_t exp_q[$];
    int errors = 0;
    int n_res = 0;
    int n_inside = 0;
    int idle_cnt = 0;
    bit done_stim = 0;

    function automatic longint fdiv14(longint v);
        if (v >= 0)
            return v / 16384;
        return -((-v + 16383) / 16384);
    endfunction

    function automatic logic [31:0] src_at(longint r, longint c);
        longint a;
        a = (r * pw_sw + c) % 65536;
        if (a < 0)
            a += 65536;
        return src_img.exists(int'(a)) ? src_img[int'(a)] : 32'h0;
    endfunction

    function automatic rot_res_t rotate_pixel(logic [8:0] row, logic [8:0] col);
        rot_res_t rr;
        longint x8, y8, c8, r8, cmax, rmax, r, c, fv, fh, v;
        logic [31:0] p, rt, b, d;
        logic lc, lr;
        x8 = longint'(col) * 256 - longint'(pw_dw / 2) * 256 + 128;
        y8 = longint'(row) * 256 - longint'(pw_dh / 2) * 256 + 128;
        c8 = fdiv14(x8 * pw_cos + y8 * pw_sin) + longint'(pw_sw / 2) * 256 - 128;
        r8 = fdiv14(y8 * pw_cos - x8 * pw_sin) + longint'(pw_sh / 2) * 256 - 128;
        cmax = (longint'(pw_sw) - 1) * 256;
        rmax = (longint'(pw_sh) - 1) * 256;
        if (c8 < 0 || r8 < 0 || c8 > cmax || r8 > rmax)
        begin
            rr.pix = WHITE;
            rr.in_img = 0;
            return rr;
        end
        r = r8 / 256;
        c = c8 / 256;
        fv = r8 % 256;
        fh = c8 % 256;
        lc = c8 >= cmax;
        lr = r8 >= rmax;
        p = src_at(r, c);
        rt = lc ? 32'h0 : src_at(r, c + 1);
        b = lr ? 32'h0 : src_at(r + 1, c);
        d = (lc || lr) ? 32'h0 : src_at(r + 1, c + 1);
        for (int ch = 0; ch < 4; ch++)
        begin
            longint vp, vr, vb, vd;
            vp = p[8*ch +: 8];
            vr = rt[8*ch +: 8];
            vb = b[8*ch +: 8];
            vd = d[8*ch +: 8];
            if (lc && lr)
                v = vp;
            else if (lc)
                v = (vp * (256 - fv) + vb * fv) >> 8;
            else if (lr)
                v = (vp * (256 - fh) + vr * fh) >> 8;
            else
                v = ((vp * (256 - fv) + vb * fv) * (256 - fh)
                    + (vr * (256 - fv) + vd * fv) * fh) >> 16;
            rr.pix[8*ch +: 8] = v[7:0];
        end
        rr.in_img = 1;
        return rr;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_SRC_WIDTH:  pw_sw = val[8:0];
            REG_SRC_HEIGHT: pw_sh = val[8:0];
            REG_DST_WIDTH:  pw_dw = val[9:0];
            REG_DST_HEIGHT: pw_dh = val[9:0];
            REG_COS:        pw_cos = val;
            REG_SIN:        pw_sin = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 0;
    endtask

    task automatic set_geometry(int sw, int sh, int dw, int dh, int cs, int sn);
        write_reg(REG_SRC_WIDTH, 16'(sw));
        write_reg(REG_SRC_HEIGHT, 16'(sh));
        write_reg(REG_DST_WIDTH, 16'(dw));
        write_reg(REG_DST_HEIGHT, 16'(dh));
        write_reg(REG_COS, 16'(cs));
        write_reg(REG_SIN, 16'(sn));
    endtask

    // send one item; a known expectation overrides the predictor.
    // push stays high after the accept so a follow-on item can go back to back.
    task automatic send_item(stim_row_t s);
        rot_res_t rr;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            push <= 0;
            repeat (gap) @(posedge clk);
        end
        push <= 1;
        cmd <= s.cmd;
        src_index <= s.idx;
        pixel_in <= s.pix;
        dst_row <= s.row;
        dst_col <= s.col;
        do
            @(posedge clk);
        while (full);
        if (s.cmd == CMD_WRITE)
            src_img[int'(s.idx)] = s.pix;
        else
        begin
            rr = rotate_pixel(s.row, s.col);
            if (s.known)
            begin
                rr.pix = s.exp_pix;
                rr.in_img = s.exp_inside;
            end
            exp_q.push_back(rr);
        end
    endtask

    task automatic drain();
        push <= 0;
        while (exp_q.size() != 0)
            @(posedge clk);
        repeat (CLEAR_LAT) @(posedge clk);
    endtask

    // fill the whole active image so no read ever hits an unwritten word
    task automatic fill_image();
        stim_row_t s;
        s = '{default: 0};
        s.cmd = CMD_WRITE;
        for (int i = 0; i < int'(pw_sw) * int'(pw_sh); i++)
        begin
            s.idx = 16'(i);
            s.pix = $urandom;
            send_item(s);
        end
    endtask

    task automatic send_read(int row, int col);
        stim_row_t s;
        s = '{default: 0};
        s.cmd = CMD_READ;
        s.row = 9'(row);
        s.col = 9'(col);
        send_item(s);
    endtask

    // result side: random stall, check against the oldest expectation
    always @(posedge clk)
    begin
        rot_res_t e;
        if (pop && !empty)
        begin
            if (exp_q.size() == 0)
            begin
                $display("%0t: unexpected item pixel=%h inside=%b", $time,
                    pixel_out, inside_res);
                errors++;
            end
            else
            begin
                e = exp_q.pop_front();
                n_res++;
                if (inside_res)
                    n_inside++;
                if (pixel_out !== e.pix)
                begin
                    $display("%0t: pixel_out expected %h actual %h", $time, e.pix, pixel_out);
                    errors++;
                end
                if (inside_res !== e.in_img)
                begin
                    $display("%0t: inside_res expected %b actual %b", $time,
                        e.in_img, inside_res);
                    errors++;
                end
            end
        end
        if ((push && !full) || (pop && !empty))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
    end

    initial
    begin
        int wait_n;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
                if (wait_n > 0)
                begin
                    pop <= 0;
                    repeat (wait_n) @(posedge clk);
                    pop <= 1;
                end
            end
            else if (!pop)
                pop <= 1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cnt >= WD_LIMIT && !done_stim)
        begin
            $display("watchdog: no progress for %0d cycles", WD_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    stim_row_t dir_tab[$];

    initial
    begin
        stim_row_t s;
        pw_sw = 256; pw_sh = 256; pw_dw = 256; pw_dh = 256; pw_cos = 16384; pw_sin = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: small 2x2 image, identity mapping, then extremes
        set_geometry(2, 2, 2, 2, 16384, 0);
        s = '{default: 0};
        s.cmd = CMD_WRITE;
        s.idx = 0; s.pix = 32'h0000_0000; dir_tab.push_back(s);
        s.idx = 1; s.pix = 32'hFFFF_FFFF; dir_tab.push_back(s);
        s.idx = 2; s.pix = 32'h8040_20FF; dir_tab.push_back(s);
        s.idx = 3; s.pix = 32'h1234_5678; dir_tab.push_back(s);
        s = '{default: 0};
        s.cmd = CMD_READ;
        // identity maps each pixel to itself; the corner pixel is copied
        s.row = 0; s.col = 0; s.known = 1; s.exp_pix = 32'h0; s.exp_inside = 1;
        dir_tab.push_back(s);
        s.row = 1; s.col = 1; s.exp_pix = 32'h1234_5678; dir_tab.push_back(s);
        s.row = 0; s.col = 1; s.exp_pix = 32'hFFFF_FFFF; dir_tab.push_back(s);
        s.row = 1; s.col = 0; s.exp_pix = 32'h8040_20FF; dir_tab.push_back(s);
        // far corner of the request space lies outside
        s.row = 511; s.col = 511; s.exp_pix = WHITE; s.exp_inside = 0; dir_tab.push_back(s);
        s.row = 0; s.col = 511; dir_tab.push_back(s);
        s.row = 511; s.col = 0; dir_tab.push_back(s);
        foreach (dir_tab[i])
            send_item(dir_tab[i]);
        drain();

        // rotated small image: blended rows, columns and interior
        set_geometry(3, 3, 5, 5, 11585, 11585);
        fill_image();
        for (int r = 0; r < 5; r++)
            for (int c = 0; c < 5; c++)
                send_read(r, c);
        drain();

        // zero source size: everything outside
        write_reg(REG_SRC_WIDTH, 16'd0);
        write_reg(REG_SRC_HEIGHT, 16'd0);
        s = '{default: 0};
        s.cmd = CMD_READ; s.known = 1; s.exp_pix = WHITE; s.exp_inside = 0;
        s.row = 2; s.col = 2;
        send_item(s);
        drain();

        // random phases with varied geometry, extremes of the angle included
        for (int ph = 0; ph < 8; ph++)
        begin
            int sw, sh, cs, sn, ang;
            sw = (ph == 7) ? 256 : $urandom_range(1, 12);
            sh = (ph == 7) ? 1 : $urandom_range(1, 12);
            case (ph % 4)
                0: begin cs = 16384; sn = 0; end
                1: begin cs = -16384; sn = 0; end
                2: begin cs = 0; sn = (ph > 3) ? -16384 : 16384; end
                default:
                begin
                    ang = $urandom_range(0, 16384);
                    cs = ang;
                    sn = $urandom_range(0, 1) ? -(16384 - ang) : (16384 - ang);
                end
            endcase
            set_geometry(sw, sh, (ph == 5) ? 512 : $urandom_range(1, 24),
                (ph == 6) ? 1 : $urandom_range(1, 24), cs, sn);
            fill_image();
            // up to four random writes land beyond the image in the address space
            for (int k = 0; k < 4; k++)
            begin
                s = '{default: 0};
                s.cmd = CMD_WRITE;
                s.idx = 16'($urandom_range(0, 65535));
                s.pix = $urandom;
                if (int'(s.idx) >= sw * sh)
                    send_item(s);
            end
            for (int k = 0; k < 40; k++)
            begin
                if (k == 20)
                    drain();  // hold off until all results are in
                if ($urandom_range(0, 9) == 0)
                    send_read($urandom_range(0, 511), $urandom_range(0, 511));
                else
                    send_read($urandom_range(0, 30), $urandom_range(0, 30));
            end
            drain();
        end

        done_stim = 1;
        repeat (CLEAR_LAT) @(posedge clk);
        $display("Run checked %0d rotated pixels (%0d inside the source)", n_res, n_inside);
        $display("over several geometries, angles and zero-size source.");
        if (errors == 0 && exp_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

### files.f
rtl/core/rotb_pkg.sv
rtl/core/rotb_front.sv
rtl/core/rotb_queue.sv
rtl/core/rotb_back.sv
rtl/core/image_rotate_bilinear.sv
sim/image_rotate_bilinear_tb.sv
